FILE: src/brt_pkg.sv
// Package of types, codes and constants shared by the block range reassembly tracker.
package brt_pkg;

	localparam int RANGE_SLOTS_DEF = 64;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BLOCK = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;

	localparam int DESC_EOF_BIT = 6;
	localparam int DESC_EOD_BIT = 3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OVERFLOW = 3'd1;
	localparam logic [2:0] ST_OVERLAP  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_COMPLETE = 3'd4;
	localparam logic [2:0] ST_HOLED    = 3'd5;
	localparam logic [2:0] ST_OVER     = 3'd6;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  descriptor;
		logic [63:0] block_count;
		logic [63:0] block_offset;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [62:0] committed_bytes;
		logic [6:0]  ranges_held;
	} rsp_t;

	typedef struct packed {
		logic [62:0] start;
		logic [62:0] stop;
	} range_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_COMMIT,
		S_EOD,
		S_FINISH
	} brt_state_t;

endpackage

FILE: src/brt_range_ram.sv
// Single-port-write, registered-read memory that holds the reserved byte ranges.
module brt_range_ram #(
	parameter int DEPTH = brt_pkg::RANGE_SLOTS_DEF,
	parameter int IW    = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [IW-1:0]   waddr,
	input  brt_pkg::range_t wdata,
	input  logic            re,
	input  logic [IW-1:0]   raddr,
	output brt_pkg::range_t rdata
);
	import brt_pkg::*;

	range_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/block_range_reassembly_tracker.sv
// Top level of the block range reassembly tracker: command sequencer, scan and transfer state.
// A start, an unknown opcode, a command after the transfer is over, an EOF or empty block without
// the EOD bit, an overflow or a full table are answered from S_EXEC; a close goes on to S_FINISH.
// A reservation scans the held ranges in S_SCAN (not with none held), answers an overlap there,
// else writes in S_COMMIT (with EOD, then S_EOD). One command at a time; the overlap scan reads
// one range per cycle from the single read port of the range memory. The receiver cannot stall.
// Reset clears all transfer state; the range memory is not cleared and is read below the count.
module block_range_reassembly_tracker #(
	parameter int RANGE_SLOTS = brt_pkg::RANGE_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  brt_pkg::cmd_t cmd,
	output logic          done,
	output brt_pkg::rsp_t result
);
	import brt_pkg::*;

	localparam int IW = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
	localparam int TW = $clog2(RANGE_SLOTS + 1);
	localparam logic [TW-1:0] SLOTS_FULL = TW'(RANGE_SLOTS);

	brt_state_t state_q, state_d;

	cmd_t        cmd_q;
	logic [62:0] hi_q;
	logic [TW-1:0] total_q;
	logic        eod_known_q;
	logic [62:0] eod_total_q;
	logic [31:0] eod_seen_q;
	logic [62:0] bytes_q;
	logic [62:0] low_q;
	logic [62:0] high_q;
	logic        over_q;
	logic [TW-1:0] scan_q;
	logic        rd_vld_s1;
	logic        rd_last_s1;
	logic [2:0]  status_q;
	logic        done_q;

	logic        accept;
	logic [63:0] sum;
	logic        overflow;
	logic [62:0] lo;
	logic        is_eof, is_eod;
	logic        hit;
	logic        whole;
	logic        eods_reached;
	logic [TW+6:0] total_ext;
	range_t      rd_data;
	range_t      wr_data;

	logic        do_clear, do_eof, do_commit, do_eod, set_over, scan_init, rd_en;
	logic        rsp_fire;
	logic [2:0]  rsp_status;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign lo       = cmd_q.block_offset[62:0];
	assign is_eof   = cmd_q.descriptor[DESC_EOF_BIT];
	assign is_eod   = cmd_q.descriptor[DESC_EOD_BIT];
	assign sum      = cmd_q.block_offset + cmd_q.block_count;
	assign overflow = cmd_q.block_count[63] || cmd_q.block_offset[63] || sum[63];
	assign hit      = (lo < rd_data.stop) && (rd_data.start < hi_q);
	assign whole    = (total_q == '0) ? (bytes_q == '0) : ((low_q == '0) && (high_q == bytes_q));
	assign eods_reached = eod_known_q && ({31'b0, eod_seen_q} >= eod_total_q);
	assign rd_en    = (state_q == S_SCAN) && (scan_q < total_q);
	assign wr_data  = '{start: lo, stop: hi_q};

	brt_range_ram #(
		.DEPTH(RANGE_SLOTS),
		.IW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (do_commit),
		.waddr(total_q[IW-1:0]),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(scan_q[IW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		do_clear   = 1'b0;
		do_eof     = 1'b0;
		do_commit  = 1'b0;
		do_eod     = 1'b0;
		set_over   = 1'b0;
		scan_init  = 1'b0;
		rsp_fire   = 1'b0;
		rsp_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d  = S_IDLE;
				rsp_fire = 1'b1;
				case (cmd_q.opcode)
					OP_START: begin
						do_clear = 1'b1;
					end
					OP_BLOCK: begin
						if (over_q) begin
							rsp_status = ST_OVER;
						end else if (is_eof || cmd_q.block_count == '0) begin
							do_eof = is_eof;
							if (is_eod) begin
								rsp_fire = 1'b0;
								state_d  = S_EOD;
							end
						end else if (overflow) begin
							set_over   = 1'b1;
							rsp_status = ST_OVERFLOW;
						end else if (total_q == SLOTS_FULL) begin
							set_over   = 1'b1;
							rsp_status = ST_FULL;
						end else if (total_q == '0) begin
							rsp_fire = 1'b0;
							state_d  = S_COMMIT;
						end else begin
							rsp_fire  = 1'b0;
							scan_init = 1'b1;
							state_d   = S_SCAN;
						end
					end
					OP_CLOSE: begin
						if (over_q) begin
							rsp_status = ST_OVER;
						end else begin
							rsp_fire = 1'b0;
							state_d  = S_FINISH;
						end
					end
					default: begin
						rsp_status = over_q ? ST_OVER : ST_OK;
					end
				endcase
			end
			S_SCAN: begin
				if (rd_vld_s1 && hit) begin
					set_over   = 1'b1;
					rsp_fire   = 1'b1;
					rsp_status = ST_OVERLAP;
					state_d    = S_IDLE;
				end else if (rd_vld_s1 && rd_last_s1) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				do_commit = 1'b1;
				if (is_eod) begin
					state_d = S_EOD;
				end else begin
					rsp_fire = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_EOD: begin
				do_eod  = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				rsp_fire = 1'b1;
				state_d  = S_IDLE;
				if (eods_reached) begin
					set_over   = 1'b1;
					rsp_status = whole ? ST_COMPLETE : ST_HOLED;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (state_q == S_EXEC) begin
			hi_q <= sum[62:0];
		end
		if (rsp_fire) begin
			status_q <= rsp_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			eod_known_q <= 1'b0;
			eod_total_q <= '0;
			eod_seen_q  <= '0;
			bytes_q     <= '0;
			low_q       <= '1;
			high_q      <= '0;
			over_q      <= 1'b0;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q     <= rsp_fire;
			rd_vld_s1  <= rd_en;
			rd_last_s1 <= rd_en && (scan_q == total_q - TW'(1));
			if (scan_init) begin
				scan_q <= '0;
			end else if (rd_en) begin
				scan_q <= scan_q + TW'(1);
			end
			if (do_clear) begin
				total_q     <= '0;
				eod_known_q <= 1'b0;
				eod_total_q <= '0;
				eod_seen_q  <= '0;
				bytes_q     <= '0;
				low_q       <= '1;
				high_q      <= '0;
				over_q      <= 1'b0;
			end else begin
				if (set_over) begin
					over_q <= 1'b1;
				end
				if (do_eof) begin
					eod_known_q <= !cmd_q.block_offset[63];
					eod_total_q <= cmd_q.block_offset[63] ? 63'd0 : lo;
				end
				if (do_commit) begin
					total_q <= total_q + TW'(1);
					bytes_q <= bytes_q + cmd_q.block_count[62:0];
					if (lo < low_q) begin
						low_q <= lo;
					end
					if (hi_q > high_q) begin
						high_q <= hi_q;
					end
				end
				if (do_eod && eod_seen_q != '1) begin
					eod_seen_q <= eod_seen_q + 32'd1;
				end
			end
		end
	end

	assign total_ext = {7'b0, total_q};
	assign done      = done_q;
	assign result    = '{status: status_q, committed_bytes: bytes_q, ranges_held: total_ext[6:0]};

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("Accepted command did not raise busy.");

	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= SLOTS_FULL)
		else $error("Range count exceeds the table size.");

	a_error_ends_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (status_q == ST_OVERFLOW || status_q == ST_OVERLAP || status_q == ST_FULL
			|| status_q == ST_COMPLETE || status_q == ST_HOLED) |-> over_q)
		else $error("Final status reported while transfer still open.");

	a_no_commit_when_over: assert property (@(posedge clk) disable iff (!arst_n)
		do_commit |-> !over_q && total_q < SLOTS_FULL)
		else $error("Range reserved after transfer end or into a full table.");

endmodule
